// File: rtl/core/mma_pkg.sv
// package for the matrix multiply-accumulate unit
// holds command codes, config indices, result kinds, reset values, the controller/datapath struct and sat32
package mma_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned SizeW = 5;
  localparam int unsigned FracW = 24;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_A  = 3'd0,
    CMD_LOAD_B  = 3'd1,
    CMD_LOAD_C  = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_READ_C  = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIZE  = 2'd0,
    CFG_ALPHA = 2'd1,
    CFG_BETA  = 2'd2
  } cfg_idx_e;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [SizeW-1:0] SizeReset  = 5'd16;
  localparam logic [DataW-1:0] AlphaReset = 32'h0100_0000;
  localparam logic [DataW-1:0] BetaReset  = 32'h0000_0000;

  // controller to datapath
  typedef struct packed {
    logic clr_acc;   // start a new dot product
    logic mac_en;    // product of last fetched pair enters the accumulator
    logic fin_en;    // saturate dot, form alpha and beta products
    logic wb_en;     // sum and write C
  } dp_cmd_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [79:0] v);
    if (v > 80'sh0_0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -80'sh0_0000_0000_8000_0000) return 32'sh8000_0000;
    return v[DataW-1:0];
  endfunction

endpackage

// File: rtl/core/mma_if.sv
// valid/ready stream interface with a generic payload
// depends on nothing
interface mma_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mma_ctrl.sv
// controller for the compute walk over i, j, k
// depends on mma_pkg
module mma_ctrl import mma_pkg::*; #(
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW:0]   n_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [AW-1:0] i_o,
  output logic [AW-1:0] j_o,
  output logic [AW-1:0] k_o,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_FIN, S_MUL, S_WB} state_e;

  state_e      state_q;
  logic [AW:0] i_q, j_q, k_q;
  logic        pend_q;
  dp_cmd_t     cmd_q;
  logic        done_q;

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign i_o    = i_q[AW-1:0];
  assign j_o    = j_q[AW-1:0];
  assign k_o    = k_q[AW-1:0];
  assign cmd_o  = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0; j_q <= '0; k_q <= '0;
      pend_q <= 1'b0;
      cmd_q <= '0;
      done_q <= 1'b0;
    end else begin
      cmd_q  <= '0;
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            i_q <= '0; j_q <= '0; k_q <= '0;
            pend_q <= 1'b0;
            if (n_i == '0) done_q <= 1'b1;
            else begin
              state_q <= S_FETCH;
              cmd_q.clr_acc <= 1'b1;
            end
          end
        end
        // memory read issued for k; its operands, then its product, are registered before it accumulates
        S_FETCH: begin
          cmd_q.mac_en <= pend_q;
          pend_q <= 1'b1;
          if (k_q + 1'b1 == n_i) state_q <= S_MUL;
          else k_q <= k_q + 1'b1;
        end
        S_MUL: begin
          cmd_q.mac_en <= 1'b1;
          state_q <= S_FIN;
        end
        S_FIN: begin
          cmd_q.fin_en <= 1'b1;
          state_q <= S_WB;
        end
        S_WB: begin
          cmd_q.wb_en <= 1'b1;
          k_q <= '0;
          pend_q <= 1'b0;
          if (j_q + 1'b1 == n_i) begin
            j_q <= '0;
            if (i_q + 1'b1 == n_i) begin
              state_q <= S_IDLE;
              done_q <= 1'b1;
            end else begin
              i_q <= i_q + 1'b1;
              cmd_q.clr_acc <= 1'b1;
              state_q <= S_FETCH;
            end
          end else begin
            j_q <= j_q + 1'b1;
            cmd_q.clr_acc <= 1'b1;
            state_q <= S_FETCH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/mma_dp.sv
// datapath: A, B, C memories, multiply-accumulate and scaling
// depends on mma_pkg
module mma_dp import mma_pkg::*; #(
  parameter int unsigned AW = 4
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [1:0]              wr_sel_i,
  input  logic [2*AW-1:0]         wr_addr_i,
  input  logic signed [DataW-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [2*AW-1:0]         rd_addr_i,
  output logic signed [DataW-1:0] rd_data_o,
  input  logic                    busy_i,
  input  logic [AW-1:0]           i_i,
  input  logic [AW-1:0]           j_i,
  input  logic [AW-1:0]           k_i,
  input  dp_cmd_t                 cmd_i,
  input  logic signed [DataW-1:0] alpha_i,
  input  logic signed [DataW-1:0] beta_i
);

  localparam int unsigned Depth = 1 << (2 * AW);
  localparam int unsigned AccW  = 2 * DataW + 2 * AW + 2;

  logic signed [DataW-1:0] mem_a [Depth];
  logic signed [DataW-1:0] mem_b [Depth];
  logic signed [DataW-1:0] mem_c [Depth];

  logic signed [DataW-1:0] a_q, b_q, c_q;
  logic signed [2*DataW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [2*DataW-1:0] pa_q, pb_q;
  logic signed [DataW-1:0] dot;
  logic signed [AccW-1:0] accf;
  logic [2*AW-1:0] cidx;
  logic [2*AW-1:0] wb_idx_q;
  logic signed [79:0] sum;

  assign cidx = {i_i, j_i};
  assign accf = acc_q >>> FracW;
  assign dot  = sat32(80'(accf));
  assign sum  = 80'(pa_q >>> FracW) + 80'(pb_q >>> FracW);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      case (wr_sel_i)
        2'd0:    mem_a[wr_addr_i] <= wr_data_i;
        2'd1:    mem_b[wr_addr_i] <= wr_data_i;
        default: mem_c[wr_addr_i] <= wr_data_i;
      endcase
    end else if (cmd_i.wb_en) begin
      mem_c[wb_idx_q] <= sat32(sum);
    end
    if (rd_en_i) rd_data_o <= mem_c[rd_addr_i];
    if (busy_i) begin
      a_q <= mem_a[{i_i, k_i}];
      b_q <= mem_b[{k_i, j_i}];
      c_q <= mem_c[cidx];
    end
    prod_q <= a_q * b_q;
    if (cmd_i.clr_acc) acc_q <= '0;
    else if (cmd_i.mac_en) acc_q <= acc_q + AccW'(prod_q);
    if (cmd_i.fin_en) begin
      pa_q <= alpha_i * dot;
      pb_q <= beta_i * c_q;
      wb_idx_q <= cidx;
    end
  end

endmodule

// File: rtl/core/matrix_multiply_accumulate_unit.sv
// matrix multiply-accumulate unit, top level
// depends on mma_pkg, mma_if, mma_ctrl, mma_dp
//
// in_if carries command items; out_if carries result items. One transfer
// happens when valid and ready are both high at a rising clock edge.
// Loads of A, B and C take one item per cycle while ready is high and give
// no result. A read of C registers its data, then the output register takes
// it; back to back reads are taken while the output is taken, but a read is
// held off while a result waits behind a full output register. Compute walks
// all n*n elements of C; each takes one memory fetch per k, then multiply,
// saturate and write back, and no item is taken meanwhile. The done result
// follows the last write back. cfg_we_i writes matrix_size, alpha_gain or beta_gain
// by index; the user must write them only while idle, the block does not enforce it.
// Reset clears control state and loads the register reset values; memory
// contents are undefined until written.
// A stalled receiver holds results in the output and skid registers; input
// is refused while the skid register is full or a read waits behind a full
// output register.
module matrix_multiply_accumulate_unit import mma_pkg::*; #(
  parameter int unsigned DIM = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mma_if.sink   in_if,
  mma_if.source out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DataW-1:0]    cfg_data_i
);

  localparam int unsigned AW = (DIM > 1) ? $clog2(DIM) : 1;

  logic [SizeW-1:0] size_q;
  logic signed [DataW-1:0] alpha_q, beta_q;
  logic [AW:0] n;
  logic busy, done;
  logic [AW-1:0] ci, cj, ck;
  dp_cmd_t dcmd;
  logic signed [DataW-1:0] rd_data;

  logic [CmdW-1:0] cmd;
  logic [IdxW-1:0] row, col;
  logic signed [DataW-1:0] val;
  logic in_range, acc, busy_any;

  assign cmd = in_if.data.command;
  assign row = in_if.data.row;
  assign col = in_if.data.col;
  assign val = in_if.data.value;
  assign in_range = (32'(row) < DIM) && (32'(col) < DIM);

  // result staging: stage 1 = read pending, stage out/skid
  logic rd_v_q, rd_in_q;
  logic [IdxW-1:0] rd_row_q, rd_col_q;
  logic o_v_q, s_v_q;
  logic o_kind_q, s_kind_q;
  logic [IdxW-1:0] o_row_q, o_col_q, s_row_q, s_col_q;
  logic [DataW-1:0] o_val_q, s_val_q;
  logic cmp_q;

  assign busy_any = busy || cmp_q;
  assign in_if.ready = !busy_any && !s_v_q && !(rd_v_q && o_v_q);
  assign acc = in_if.valid && in_if.ready;

  always_comb begin
    if (size_q > SizeW'(DIM)) n = (AW+1)'(DIM);
    else n = (AW+1)'(size_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SizeReset;
      alpha_q <= AlphaReset;
      beta_q  <= BetaReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE:  size_q  <= cfg_data_i[SizeW-1:0];
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_BETA:  beta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mma_ctrl #(.AW(AW)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(acc && cmd == CMD_COMPUTE),
    .n_i(n), .busy_o(busy), .done_o(done),
    .i_o(ci), .j_o(cj), .k_o(ck), .cmd_o(dcmd)
  );

  mma_dp #(.AW(AW)) u_dp (
    .clk_i,
    .wr_en_i(acc && cmd <= CMD_LOAD_C && in_range),
    .wr_sel_i(cmd[1:0]),
    .wr_addr_i({row[AW-1:0], col[AW-1:0]}),
    .wr_data_i(val),
    .rd_en_i(acc && cmd == CMD_READ_C),
    .rd_addr_i({row[AW-1:0], col[AW-1:0]}),
    .rd_data_o(rd_data),
    .busy_i(busy), .i_i(ci), .j_i(cj), .k_i(ck), .cmd_i(dcmd),
    .alpha_i(alpha_q), .beta_i(beta_q)
  );

  logic n_v, n_kind;
  logic [IdxW-1:0] n_row, n_col;
  logic [DataW-1:0] n_val;

  always_comb begin
    n_v = rd_v_q || done;
    n_kind = done ? KIND_DONE : KIND_READ;
    n_row = done ? '0 : rd_row_q;
    n_col = done ? '0 : rd_col_q;
    n_val = done ? '0 : (rd_in_q ? rd_data : '0);
  end

  logic pop;
  assign pop = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; rd_in_q <= 1'b0;
      o_v_q <= 1'b0; s_v_q <= 1'b0; cmp_q <= 1'b0;
    end else begin
      rd_v_q  <= acc && cmd == CMD_READ_C;
      rd_in_q <= in_range;
      if (acc && cmd == CMD_COMPUTE) cmp_q <= 1'b1;
      else if (done) cmp_q <= 1'b0;
      if (!o_v_q || pop) begin
        if (s_v_q) begin
          o_v_q <= 1'b1;
          s_v_q <= n_v;
        end else o_v_q <= n_v;
      end else if (n_v) s_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_row_q <= row;
      rd_col_q <= col;
    end
    if (!o_v_q || pop) begin
      if (s_v_q) begin
        o_kind_q <= s_kind_q; o_row_q <= s_row_q;
        o_col_q <= s_col_q; o_val_q <= s_val_q;
        s_kind_q <= n_kind; s_row_q <= n_row;
        s_col_q <= n_col; s_val_q <= n_val;
      end else begin
        o_kind_q <= n_kind; o_row_q <= n_row;
        o_col_q <= n_col; o_val_q <= n_val;
      end
    end else if (n_v) begin
      s_kind_q <= n_kind; s_row_q <= n_row;
      s_col_q <= n_col; s_val_q <= n_val;
    end
  end

  assign out_if.valid          = o_v_q;
  assign out_if.data.kind      = o_kind_q;
  assign out_if.data.out_row   = o_row_q;
  assign out_if.data.out_col   = o_col_q;
  assign out_if.data.out_value = o_val_q;

endmodule
